### hw/rtl/hrp_pkg.sv
// Package for the HTTP response header parser: state encoding, parser
// register set, status and role codes, and character helper functions.
// Used by hrp_step and http_response_header_parser_core.
`default_nettype none
package hrp_pkg;

  typedef enum logic [18:0] {
    S_H      = 19'h00001,
    S_T1     = 19'h00002,
    S_T2     = 19'h00004,
    S_P      = 19'h00008,
    S_SLASH  = 19'h00010,
    S_MAJ0   = 19'h00020,
    S_MAJ    = 19'h00040,
    S_MIN0   = 19'h00080,
    S_MIN    = 19'h00100,
    S_CODE   = 19'h00200,
    S_PHRASE = 19'h00400,
    S_NL1    = 19'h00800,
    S_LINE   = 19'h01000,
    S_LWS    = 19'h02000,
    S_NAME   = 19'h04000,
    S_SP     = 19'h08000,
    S_VALUE  = 19'h10000,
    S_NL2    = 19'h20000,
    S_NL3    = 19'h40000
  } hrp_fsm_t;

  localparam logic [1:0] STAT_CONT  = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_ERROR = 2'd2;

  localparam logic [2:0] ROLE_SYNTAX = 3'd0;
  localparam logic [2:0] ROLE_PHRASE = 3'd1;
  localparam logic [2:0] ROLE_FIRST  = 3'd2;
  localparam logic [2:0] ROLE_NAME   = 3'd3;
  localparam logic [2:0] ROLE_VALUE  = 3'd4;

  localparam logic [1:0] FLAG_CL = 2'b01;
  localparam logic [1:0] FLAG_CR = 2'b10;
  localparam logic [3:0] LEN_CL  = 4'd14;
  localparam logic [3:0] LEN_CR  = 4'd13;

  localparam logic [1:0] NUM_BLANKS = 2'd0;
  localparam logic [1:0] NUM_SIGN   = 2'd1;
  localparam logic [1:0] NUM_DIGITS = 2'd2;
  localparam logic [1:0] NUM_DONE   = 2'd3;

  localparam logic [1:0] RNG_FIRST = 2'd0;
  localparam logic [1:0] RNG_LAST  = 2'd1;
  localparam logic [1:0] RNG_TAIL  = 2'd2;

  typedef struct packed {
    hrp_fsm_t    pst;
    logic [15:0] major;
    logic [15:0] minor;
    logic [15:0] code;
    logic [7:0]  hdr_cnt;
    logic [31:0] byte_cnt;
    logic [31:0] length;
    logic [31:0] rng_first;
    logic [31:0] rng_last;
    logic [3:0]  match_pos;
    logic [1:0]  match_flags;
    logic [31:0] acc;
    logic [1:0]  num_phase;
    logic        num_neg;
    logic [1:0]  rng_part;
    logic [31:0] pend_first;
    logic        rng_space;
  } hrp_state_t;

  localparam hrp_state_t HRP_RESET = '{
    pst: S_H, major: 16'd0, minor: 16'd0, code: 16'd0, hdr_cnt: 8'd0,
    byte_cnt: 32'd0, length: 32'd0, rng_first: 32'd0, rng_last: 32'd0,
    match_pos: 4'd0, match_flags: 2'b00, acc: 32'd0, num_phase: NUM_BLANKS,
    num_neg: 1'b0, rng_part: RNG_FIRST, pend_first: 32'd0, rng_space: 1'b0
  };

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= 8'd31) || (c == 8'd127);
  endfunction

  function automatic logic is_tspec(input logic [7:0] c);
    logic r;
    case (c)
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
      8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: begin
        r = 1'b1;
      end
      default: begin
        r = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic logic bad_name(input logic [7:0] c);
    return c[7] || is_ctl(c) || is_tspec(c);
  endfunction

  // Characters of "Content-Length" and "Content-Range" by position.
  function automatic logic [7:0] cl_char(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0:    r = "C";
      4'd1:    r = "o";
      4'd2:    r = "n";
      4'd3:    r = "t";
      4'd4:    r = "e";
      4'd5:    r = "n";
      4'd6:    r = "t";
      4'd7:    r = "-";
      4'd8:    r = "L";
      4'd9:    r = "e";
      4'd10:   r = "n";
      4'd11:   r = "g";
      4'd12:   r = "t";
      4'd13:   r = "h";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cr_char(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd8:    r = "R";
      4'd9:    r = "a";
      4'd10:   r = "n";
      4'd11:   r = "g";
      4'd12:   r = "e";
      default: r = (p < 4'd8) ? cl_char(p) : 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] dec16(input logic [15:0] v, input logic [7:0] c);
    return (v << 3) + (v << 1) + {12'd0, c[3:0]};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/http_response_header_parser_core.sv
// Top level of the HTTP response header parser: parser state registers,
// result register and stream handshake. Uses hrp_pkg and hrp_step.
//
//  channel | dir | tdata                          | tuser
//  in_     | in  | byte_in[7:0]                   | new_message[0]
//  out_    | out | status..bytes_consumed [188:0] | none
//
// One byte per cycle while results are taken; each result is registered and
// appears in the cycle after its byte is taken, from hrp_step's combinational logic.
// Synchronous active-low reset puts the parser at the start of a header.
// The result register holds until taken; a new byte is taken in the same
// cycle as the waiting result leaves, so throughput stays one per cycle.
`default_nettype none
module http_response_header_parser_core
  import hrp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // byte_in[7:0]
  input  wire logic [0:0]   in_tuser,   // new_message[0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status[1:0] byte_role[4:2] version_major[20:5] version_minor[36:21]
  // status_code[52:37] body_length[84:53] range_start[116:85]
  // range_end[148:117] header_count[156:149] bytes_consumed[188:157]
  output logic [191:0]      out_tdata
);

  hrp_state_t  state_r;
  hrp_state_t  state_nxt;
  logic [1:0]  status_nxt;
  logic [2:0]  role_nxt;
  logic        out_valid_r;
  logic [191:0] out_data_r;
  logic        accept;

  hrp_step u_step (
    .cur     (state_r),
    .c       (in_tdata),
    .new_msg (in_tuser[0]),
    .nxt     (state_nxt),
    .status  (status_nxt),
    .role    (role_nxt)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= HRP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {3'd0, state_nxt.byte_cnt, state_nxt.hdr_cnt,
                     state_nxt.rng_last, state_nxt.rng_first, state_nxt.length,
                     state_nxt.code, state_nxt.minor, state_nxt.major,
                     role_nxt, status_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted byte produced no result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'b11)
    else $error("undefined status code");

  a_error_role: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == STAT_ERROR) |-> out_tdata[4:2] == ROLE_SYNTAX)
    else $error("error result carries a byte role");

  a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser[0]) |=> out_tdata[188:157] == 32'd1)
    else $error("byte count wrong after message restart");

endmodule
`default_nettype wire

### hw/rtl/hrp_step.sv
// Next-state logic of the header parser for one byte.
// Depends on hrp_pkg for the state record and character helpers.
`default_nettype none
module hrp_step
  import hrp_pkg::*;
(
  input  wire hrp_state_t cur,
  input  wire logic [7:0] c,
  input  wire logic       new_msg,
  output hrp_state_t      nxt,
  output logic [1:0]      status,
  output logic [2:0]      role
);

  function automatic hrp_state_t num_feed(input hrp_state_t s, input logic [7:0] ch);
    hrp_state_t r;
    logic       skip;
    r = s;
    skip = 1'b0;
    if (r.num_phase == NUM_BLANKS) begin
      if (ch == 8'h20) begin
        skip = 1'b1;
      end else if (ch == 8'h2b || ch == 8'h2d) begin
        r.num_neg = (ch == 8'h2d);
        r.num_phase = NUM_SIGN;
        skip = 1'b1;
      end
    end
    if (!skip && r.num_phase != NUM_DONE) begin
      if (is_dig(ch)) begin
        r.acc = (r.acc << 3) + (r.acc << 1) + {28'd0, ch[3:0]};
        r.num_phase = NUM_DIGITS;
      end else begin
        r.num_phase = NUM_DONE;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] num_value(input hrp_state_t s);
    return s.num_neg ? (32'd0 - s.acc) : s.acc;
  endfunction

  function automatic hrp_state_t name_feed(input hrp_state_t s, input logic [7:0] ch);
    hrp_state_t r;
    r = s;
    if (r.match_pos >= LEN_CL || cl_char(r.match_pos) != ch) begin
      r.match_flags = r.match_flags & ~FLAG_CL;
    end
    if (r.match_pos >= LEN_CR || cr_char(r.match_pos) != ch) begin
      r.match_flags = r.match_flags & ~FLAG_CR;
    end
    if (r.match_pos != 4'd15) begin
      r.match_pos = r.match_pos + 4'd1;
    end
    return r;
  endfunction

  function automatic hrp_state_t value_feed(input hrp_state_t s, input logic [7:0] ch);
    hrp_state_t r;
    r = s;
    if ((r.match_flags & FLAG_CL) != 2'b00) begin
      r = num_feed(r, ch);
    end else if ((r.match_flags & FLAG_CR) != 2'b00) begin
      if (!r.rng_space) begin
        if (ch == 8'h20) begin
          r.rng_space = 1'b1;
        end
      end else if (r.rng_part == RNG_FIRST) begin
        if (ch == 8'h2d) begin
          r.pend_first = num_value(r);
          r.acc = 32'd0;
          r.num_phase = NUM_BLANKS;
          r.num_neg = 1'b0;
          r.rng_part = RNG_LAST;
        end else begin
          r = num_feed(r, ch);
        end
      end else if (r.rng_part == RNG_LAST) begin
        if (ch == 8'h2f) begin
          r.rng_part = RNG_TAIL;
        end else begin
          r = num_feed(r, ch);
        end
      end
    end
    return r;
  endfunction

  hrp_state_t b;
  hrp_state_t n;
  logic       ok;

  always_comb begin
    b = new_msg ? HRP_RESET : cur;
    b.byte_cnt = b.byte_cnt + 32'd1;
    n = b;
    ok = 1'b1;
    status = STAT_CONT;
    role = ROLE_SYNTAX;
    case (b.pst)
      S_H: begin
        ok = (c == "H");
        n.pst = S_T1;
      end
      S_T1: begin
        ok = (c == "T");
        n.pst = S_T2;
      end
      S_T2: begin
        ok = (c == "T");
        n.pst = S_P;
      end
      S_P: begin
        ok = (c == "P");
        n.pst = S_SLASH;
      end
      S_SLASH: begin
        ok = (c == "/");
        n.pst = S_MAJ0;
        n.major = 16'd0;
        n.minor = 16'd0;
      end
      S_MAJ0, S_MAJ: begin
        if (b.pst == S_MAJ && c == ".") begin
          n.pst = S_MIN0;
        end else if (is_dig(c)) begin
          n.major = dec16(b.major, c);
          n.pst = S_MAJ;
        end else begin
          ok = 1'b0;
        end
      end
      S_MIN0, S_MIN: begin
        if (b.pst == S_MIN && c == " ") begin
          n.code = 16'd0;
          n.pst = S_CODE;
        end else if (is_dig(c)) begin
          n.minor = dec16(b.minor, c);
          n.pst = S_MIN;
        end else begin
          ok = 1'b0;
        end
      end
      S_CODE: begin
        if (c == " ") begin
          n.pst = S_PHRASE;
        end else if (c == 8'h0d) begin
          n.pst = S_NL1;
        end else if (is_dig(c)) begin
          n.code = dec16(b.code, c);
        end else begin
          ok = 1'b0;
        end
      end
      S_PHRASE: begin
        if (c == 8'h0d) begin
          n.pst = S_NL1;
        end else begin
          role = ROLE_PHRASE;
        end
      end
      S_NL1: begin
        ok = (c == 8'h0a);
        n.pst = S_LINE;
      end
      S_LINE: begin
        if (c == 8'h0d) begin
          n.pst = S_NL3;
        end else if (b.hdr_cnt != 8'd0 && (c == 8'h20 || c == 8'h09)) begin
          n.pst = S_LWS;
        end else if (bad_name(c)) begin
          ok = 1'b0;
        end else begin
          if (b.hdr_cnt != 8'd255) begin
            n.hdr_cnt = b.hdr_cnt + 8'd1;
          end
          n.match_pos = 4'd0;
          n.match_flags = FLAG_CL | FLAG_CR;
          n.acc = 32'd0;
          n.num_phase = NUM_BLANKS;
          n.num_neg = 1'b0;
          n.rng_part = RNG_FIRST;
          n.rng_space = 1'b0;
          n.pend_first = 32'd0;
          n = name_feed(n, c);
          n.pst = S_NAME;
          role = ROLE_FIRST;
        end
      end
      S_LWS: begin
        if (c == 8'h0d) begin
          n.pst = S_NL2;
        end else if (c == 8'h20 || c == 8'h09) begin
          n.pst = S_LWS;
        end else if (is_ctl(c)) begin
          ok = 1'b0;
        end else begin
          n = value_feed(b, c);
          n.pst = S_VALUE;
          role = ROLE_VALUE;
        end
      end
      S_NAME: begin
        if (c == ":") begin
          if (b.match_pos != LEN_CL) begin
            n.match_flags = n.match_flags & ~FLAG_CL;
          end
          if (b.match_pos != LEN_CR) begin
            n.match_flags = n.match_flags & ~FLAG_CR;
          end
          n.pst = S_SP;
        end else if (bad_name(c)) begin
          ok = 1'b0;
        end else begin
          n = name_feed(b, c);
          role = ROLE_NAME;
        end
      end
      S_SP: begin
        ok = (c == " ");
        n.pst = S_VALUE;
      end
      S_VALUE: begin
        if (c == 8'h0d) begin
          n.pst = S_NL2;
        end else if (is_ctl(c)) begin
          ok = 1'b0;
        end else begin
          n = value_feed(b, c);
          role = ROLE_VALUE;
        end
      end
      S_NL2: begin
        ok = (c == 8'h0a);
        n.pst = S_LINE;
        if ((b.match_flags & FLAG_CL) != 2'b00) begin
          n.length = num_value(b);
        end else if ((b.match_flags & FLAG_CR) != 2'b00 && b.rng_space) begin
          if (b.rng_part == RNG_FIRST) begin
            n.rng_first = num_value(b);
            n.rng_last = 32'd0;
          end else begin
            n.rng_first = b.pend_first;
            n.rng_last = num_value(b);
          end
        end
      end
      S_NL3: begin
        ok = (c == 8'h0a);
        status = STAT_DONE;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    // A rejected byte changes nothing but the byte count, apart from a new_msg restart.
    if (!ok) begin
      n = b;
      status = STAT_ERROR;
      role = ROLE_SYNTAX;
    end
    nxt = n;
  end

endmodule
`default_nettype wire

### verif/tb_http_response_header_parser_core.sv
// Testbench for http_response_header_parser_core: streams header bytes in,
// predicts every result with a behavioral parser model and compares fields.
// Depends on hrp_pkg and the core RTL.
`timescale 1ns / 100ps
module tb_http_response_header_parser_core;
  import hrp_pkg::*;

  typedef struct packed {
    logic [7:0] c;
    logic       restart;
  } hdr_byte_t;

  // Declared from the highest bits of the result down.
  typedef struct packed {
    logic [31:0] byte_cnt;
    logic [7:0]  hdr_cnt;
    logic [31:0] rlast;
    logic [31:0] rfirst;
    logic [31:0] length;
    logic [15:0] code;
    logic [15:0] minor;
    logic [15:0] major;
    logic [2:0]  role;
    logic [1:0]  status;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [191:0] out_tdata;

  http_response_header_parser_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  hdr_byte_t     pending_bytes[$];
  parse_result_t expected_results[$];
  int            fail_count = 0;
  bit            hold_receiver = 0;
  bit            pause_sender = 0;
  bit            in_taken = 0;
  bit            out_taken = 0;

  // Parser model state.
  hrp_fsm_t    m_st;
  logic [15:0] m_major, m_minor, m_code;
  logic [7:0]  m_hdr;
  logic [31:0] m_bytes, m_len, m_rfirst, m_rlast, m_acc, m_pend;
  logic [3:0]  m_pos;
  logic [1:0]  m_flags, m_phase, m_part;
  logic        m_neg, m_space;

  function automatic logic ctl_byte(logic [7:0] c);
    return c <= 8'd31 || c == 8'd127;
  endfunction

  function automatic logic bad_name_char(logic [7:0] c);
    string sep;
    sep = "()<>@,;:\\\"/[]?={} \t";
    if (c > 8'd127 || ctl_byte(c)) return 1'b1;
    foreach (sep[i]) if (sep[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [15:0] times_ten(logic [15:0] v, logic [7:0] c);
    return v * 16'd10 + 16'(c - "0");
  endfunction

  function automatic logic digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void model_reset();
    m_st = S_H; m_major = 0; m_minor = 0; m_code = 0; m_hdr = 0; m_bytes = 0;
    m_len = 0; m_rfirst = 0; m_rlast = 0; m_pos = 0; m_flags = 0;
    m_acc = 0; m_phase = NUM_BLANKS; m_neg = 0; m_part = RNG_FIRST;
    m_pend = 0; m_space = 0;
  endfunction

  function automatic logic [31:0] signed_value();
    return m_neg ? 32'd0 - m_acc : m_acc;
  endfunction

  function automatic void atoi_feed(logic [7:0] c);
    if (m_phase == NUM_BLANKS) begin
      if (c == " ") return;
      if (c == "+" || c == "-") begin
        m_neg = (c == "-"); m_phase = NUM_SIGN; return;
      end
    end
    if (m_phase == NUM_DONE) return;
    if (digit(c)) begin
      m_acc = m_acc * 32'd10 + 32'(c - "0"); m_phase = NUM_DIGITS;
    end else begin
      m_phase = NUM_DONE;
    end
  endfunction

  function automatic void match_name(logic [7:0] c);
    string cl, cr;
    cl = "Content-Length"; cr = "Content-Range";
    if (m_pos >= 14 || cl[m_pos] != c) m_flags &= ~FLAG_CL;
    if (m_pos >= 13 || cr[m_pos] != c) m_flags &= ~FLAG_CR;
    if (m_pos < 15) m_pos++;
  endfunction

  function automatic void feed_value(logic [7:0] c);
    if (m_flags & FLAG_CL) begin
      atoi_feed(c);
    end else if (m_flags & FLAG_CR) begin
      if (!m_space) begin
        if (c == " ") m_space = 1;
      end else if (m_part == RNG_FIRST) begin
        if (c == "-") begin
          m_pend = signed_value(); m_acc = 0; m_phase = NUM_BLANKS; m_neg = 0;
          m_part = RNG_LAST;
        end else begin
          atoi_feed(c);
        end
      end else if (m_part == RNG_LAST) begin
        if (c == "/") m_part = RNG_TAIL;
        else atoi_feed(c);
      end
    end
  endfunction

  function automatic parse_result_t parse_byte(hdr_byte_t b);
    parse_result_t r;
    logic [7:0] c;
    logic ok;
    c = b.c; ok = 1; r.status = STAT_CONT; r.role = ROLE_SYNTAX;
    if (b.restart) model_reset();
    m_bytes++;
    case (m_st)
      S_H:  if (c == "H") m_st = S_T1; else ok = 0;
      S_T1: if (c == "T") m_st = S_T2; else ok = 0;
      S_T2: if (c == "T") m_st = S_P; else ok = 0;
      S_P:  if (c == "P") m_st = S_SLASH; else ok = 0;
      S_SLASH: begin
        if (c == "/") begin
          m_st = S_MAJ0; m_major = 0; m_minor = 0;
        end else ok = 0;
      end
      S_MAJ0, S_MAJ: begin
        if (m_st == S_MAJ && c == ".") m_st = S_MIN0;
        else if (digit(c)) begin
          m_major = times_ten(m_major, c); m_st = S_MAJ;
        end else ok = 0;
      end
      S_MIN0, S_MIN: begin
        if (m_st == S_MIN && c == " ") begin
          m_code = 0; m_st = S_CODE;
        end else if (digit(c)) begin
          m_minor = times_ten(m_minor, c); m_st = S_MIN;
        end else ok = 0;
      end
      S_CODE: begin
        if (c == " ") m_st = S_PHRASE;
        else if (c == 8'h0d) m_st = S_NL1;
        else if (digit(c)) m_code = times_ten(m_code, c);
        else ok = 0;
      end
      S_PHRASE: if (c == 8'h0d) m_st = S_NL1; else r.role = ROLE_PHRASE;
      S_NL1: if (c == 8'h0a) m_st = S_LINE; else ok = 0;
      S_LINE: begin
        if (c == 8'h0d) m_st = S_NL3;
        else if (m_hdr != 0 && (c == " " || c == 8'h09)) m_st = S_LWS;
        else if (bad_name_char(c)) ok = 0;
        else begin
          if (m_hdr < 8'd255) m_hdr++;
          m_pos = 0; m_flags = FLAG_CL | FLAG_CR; m_acc = 0;
          m_phase = NUM_BLANKS; m_neg = 0; m_part = RNG_FIRST;
          m_space = 0; m_pend = 0;
          match_name(c); m_st = S_NAME; r.role = ROLE_FIRST;
        end
      end
      S_LWS: begin
        if (c == 8'h0d) m_st = S_NL2;
        else if (c == " " || c == 8'h09) begin
        end else if (ctl_byte(c)) ok = 0;
        else begin
          m_st = S_VALUE; feed_value(c); r.role = ROLE_VALUE;
        end
      end
      S_NAME: begin
        if (c == ":") begin
          if (m_pos != LEN_CL) m_flags &= ~FLAG_CL;
          if (m_pos != LEN_CR) m_flags &= ~FLAG_CR;
          m_st = S_SP;
        end else if (bad_name_char(c)) ok = 0;
        else begin
          match_name(c); r.role = ROLE_NAME;
        end
      end
      S_SP: if (c == " ") m_st = S_VALUE; else ok = 0;
      S_VALUE: begin
        if (c == 8'h0d) m_st = S_NL2;
        else if (ctl_byte(c)) ok = 0;
        else begin
          feed_value(c); r.role = ROLE_VALUE;
        end
      end
      S_NL2: begin
        if (c == 8'h0a) begin
          m_st = S_LINE;
          if (m_flags & FLAG_CL) m_len = signed_value();
          else if ((m_flags & FLAG_CR) && m_space) begin
            if (m_part == RNG_FIRST) begin
              m_rfirst = signed_value(); m_rlast = 0;
            end else begin
              m_rfirst = m_pend; m_rlast = signed_value();
            end
          end
        end else ok = 0;
      end
      S_NL3: if (c == 8'h0a) r.status = STAT_DONE; else ok = 0;
      default: ok = 0;
    endcase
    if (!ok) begin
      r.status = STAT_ERROR; r.role = ROLE_SYNTAX;
    end
    r.major = m_major; r.minor = m_minor; r.code = m_code; r.length = m_len;
    r.rfirst = m_rfirst; r.rlast = m_rlast; r.hdr_cnt = m_hdr;
    r.byte_cnt = m_bytes;
    return r;
  endfunction

  // Stimulus helpers.
  task automatic push_text(string s, bit restart_first);
    hdr_byte_t b;
    foreach (s[i]) begin
      b.c = s[i]; b.restart = restart_first && i == 0;
      pending_bytes = {pending_bytes, b};
    end
  endtask

  function automatic string rand_digits(int n);
    string s;
    s = "";
    repeat (n) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_token();
    string s;
    byte c;
    s = "";
    repeat ($urandom_range(1, 6)) begin
      do c = 8'($urandom_range(33, 126)); while (bad_name_char(c));
      s = {s, string'(c)};
    end
    return s;
  endfunction

  function automatic string rand_number();
    string s;
    int k;
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, " "};
    k = $urandom_range(0, 3);
    if (k == 1) s = {s, "-"};
    else if (k == 2) s = {s, "+"};
    s = {s, rand_digits($urandom_range(0, 11))};
    if ($urandom_range(0, 4) == 0) s = {s, "x9"};
    return s;
  endfunction

  function automatic string rand_message();
    string s, v;
    int k;
    s = {"HTTP/", rand_digits($urandom_range(1, 2)), ".", rand_digits($urandom_range(1, 2)),
         " ", rand_digits($urandom_range(1, 3))};
    if ($urandom_range(0, 3) != 0) s = {s, " OK", string'(8'($urandom_range(128, 255)))};
    s = {s, "\r\n"};
    repeat ($urandom_range(0, 3)) begin
      k = $urandom_range(0, 3);
      if (k == 0) s = {s, "Content-Length: ", rand_number()};
      else if (k == 1) begin
        v = $urandom_range(0, 3) == 0 ? "" : "bytes ";
        s = {s, "Content-Range: ", v, rand_number()};
        if ($urandom_range(0, 3) != 0) s = {s, "-", rand_number()};
        if ($urandom_range(0, 1)) s = {s, "/", rand_digits(3)};
      end else s = {s, rand_token(), ": ", rand_token()};
      s = {s, "\r\n"};
      if ($urandom_range(0, 5) == 0) s = {s, "\t ", rand_digits(2), "\r\n"};
    end
    s = {s, "\r\n"};
    return s;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_http_response_header_parser_core NOT OK");
    $finish;
  end

  // Handshakes are recorded at the rising edge where they take place.
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    out_taken = rst_n && out_tvalid && out_tready;
  end

  // Driver: one transaction per handshake, new values at the falling edge.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_tvalid = 1'b0;
        send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
      end
      if (!in_tvalid) begin
        if (send_gap > 0) send_gap--;
        else if (!pause_sender && pending_bytes.size() > 0) begin
          hdr_byte_t b;
          b = pending_bytes.pop_front();
          in_tdata = b.c; in_tuser = b.restart; in_tvalid = 1'b1;
          expected_results = {expected_results, parse_byte(b)};
        end
      end
    end
  end

  int recv_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken)
        recv_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
      if (hold_receiver || recv_gap > 0) begin
        out_tready = 1'b0;
        if (recv_gap > 0) recv_gap--;
      end else out_tready = 1'b1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      parse_result_t got, exp;
      got = parse_result_t'(out_tdata[188:0]);
      if (expected_results.size() == 0) begin
        $error("result with no byte outstanding");
        fail_count++;
      end else begin
        exp = expected_results.pop_front();
        if (got.status !== exp.status)
          begin $error("status exp %0d got %0d", exp.status, got.status); fail_count++; end
        if (got.role !== exp.role)
          begin $error("byte_role exp %0d got %0d", exp.role, got.role); fail_count++; end
        if (got.major !== exp.major)
          begin $error("version_major exp %0d got %0d", exp.major, got.major); fail_count++; end
        if (got.minor !== exp.minor)
          begin $error("version_minor exp %0d got %0d", exp.minor, got.minor); fail_count++; end
        if (got.code !== exp.code)
          begin $error("status_code exp %0d got %0d", exp.code, got.code); fail_count++; end
        if (got.length !== exp.length) begin
          $error("body_length exp %0d got %0d", $signed(exp.length), $signed(got.length));
          fail_count++;
        end
        if (got.rfirst !== exp.rfirst) begin
          $error("range_start exp %0d got %0d", $signed(exp.rfirst), $signed(got.rfirst));
          fail_count++;
        end
        if (got.rlast !== exp.rlast) begin
          $error("range_end exp %0d got %0d", $signed(exp.rlast), $signed(got.rlast));
          fail_count++;
        end
        if (got.hdr_cnt !== exp.hdr_cnt)
          begin $error("header_count exp %0d got %0d", exp.hdr_cnt, got.hdr_cnt); fail_count++; end
        if (got.byte_cnt !== exp.byte_cnt)
          begin $error("bytes_consumed exp %0d got %0d", exp.byte_cnt, got.byte_cnt);
            fail_count++; end
      end
    end
  end

  initial begin
    string s;
    int n;
    bit paused_once;
    paused_once = 0;
    model_reset();
    // Directed: full header with both numeric fields, fold, done three times, errors.
    push_text({"HTTP/1.1 206 Partial\r\nContent-Range: bytes 10-99/200\r\n",
               "Content-Length: -42\r\n\tX\r\nA: b\r\n\r\n\n\nZ"}, 1);
    push_text("HTTP/99999.70000 65536\r\nContent-Range: 5\r\n\r\n", 1);
    push_text({"HTTP/1.0 200 \r\n", string'(8'd255), string'(8'd0), " x\r\n"}, 1);
    push_text("Content-Range:x", 0);
    push_text("HTTP/2.0 1\r\nContent-Length: 4294967295\r\n\r\n", 1);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_bytes.size() > 40) @(posedge clk);
    // Hold the receiver off for a long stretch while bytes are still pending.
    hold_receiver = 1;
    repeat (60) @(posedge clk);
    hold_receiver = 0;
    n = 0;
    while (n < 320) begin
      if ($urandom_range(0, 7) == 0) begin
        // Noise, drawn from all byte values.
        s = "";
        repeat ($urandom_range(1, 6)) s = {s, string'(8'($urandom_range(0, 255)))};
        push_text(s, $urandom_range(0, 1));
      end else begin
        s = rand_message();
        if ($urandom_range(0, 4) == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
        push_text(s, 1);
      end
      n += s.len();
      if (n > 150 && !paused_once) begin
        while (pending_bytes.size() > 0) @(posedge clk);
        pause_sender = 1;
        while (expected_results.size() > 0) @(posedge clk);
        pause_sender = 0;
        paused_once = 1;
      end
    end
    while (pending_bytes.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) $display("tb_http_response_header_parser_core OK");
    else $display("tb_http_response_header_parser_core NOT OK");
    $finish;
  end
endmodule
